// ----- design/srft_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// srft_pkg: shared types and constants of the sound RAM FIFO transfer unit
// Function codes, transfer types, configuration indexes and the structs that
// pass between the FIFO, the transfer engine and the top level.
// -----------------------------------------------------------------------------
package srft_pkg;

	// FIFO geometry
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Field widths
	localparam int WORD_W  = 16;
	localparam int PTR_W   = 19;
	localparam int INDEX_W = 18;
	localparam int PHASE_W = 3;
	localparam int MODE_W  = 2;
	localparam int TYPE_W  = 3;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 3;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_ADDR = 2'd1,
		FUNC_PUSH = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;

	localparam logic [TYPE_W-1:0] TYPE_NORMAL = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_REP2   = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_REP4   = 3'd4;
	localparam logic [TYPE_W-1:0] TYPE_REP8   = 3'd5;

	localparam logic [CIDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_TYPE = 2'd1;

	localparam logic [TYPE_W-1:0] TYPE_RESET = TYPE_NORMAL;

	typedef struct packed {
		func_t             func;
		logic [WORD_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic              ram_write;
		logic [INDEX_W-1:0] ram_index;
		logic [WORD_W-1:0] ram_data;
		logic              busy_res;
		logic              fifo_overflow;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TYPE_W-1:0] xfer_type;
	} cfg_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [WORD_W-1:0] wdata;
	} fifo_ctl_t;

	typedef struct packed {
		logic               empty;
		logic               full;
		logic [FIFO_CW-1:0] count;
		logic [WORD_W-1:0]  rdata;
	} fifo_stat_t;

endpackage

// ----- design/srft_fifo.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// srft_fifo: halfword FIFO of the transfer unit
// Register storage with read and write pointers and a fill count; the head
// word is visible combinationally for a pop in the same cycle.
// -----------------------------------------------------------------------------
module srft_fifo
	import srft_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_ctl_t  ctl,
	output fifo_stat_t stat
);

	logic [WORD_W-1:0]  words_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [FIFO_AW-1:0] ptr_next(input logic [FIFO_AW-1:0] p);
		if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + FIFO_AW'(1);
	endfunction

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.count = count_q;
	assign stat.rdata = words_q[rd_q];

	// drop pushes into a full FIFO and pops from an empty one
	assign do_push = ctl.push && !stat.full;
	assign do_pop  = ctl.pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			words_q[wr_q] <= ctl.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (do_pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

endmodule

// ----- design/srft_engine.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// srft_engine: transfer engine of the sound RAM FIFO transfer unit
// Decodes one item, drives the FIFO, holds the byte pointer, held word,
// repeat phase and busy flag, and forms the result.
// -----------------------------------------------------------------------------
module srft_engine
	import srft_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  item_t      item,
	input  cfg_t       cfg,
	input  fifo_stat_t fifo_stat,
	output fifo_ctl_t  fifo_ctl,
	output result_t    result
);

	logic [PTR_W-1:0]   ptr_q;
	logic [WORD_W-1:0]  held_q;
	logic [PHASE_W-1:0] phase_q;
	logic               busy_q;

	logic [PTR_W-1:0]   ptr_d;
	logic [WORD_W-1:0]  held_d;
	logic [PHASE_W-1:0] phase_d;
	logic [PHASE_W-1:0] phase_inc;
	logic               busy_d;
	logic               can_xfer;
	logic               pop;

	assign can_xfer  = (cfg.mode == MODE_MANUAL) && !fifo_stat.empty;
	assign phase_inc = phase_q + PHASE_W'(1);

	always_comb begin
		ptr_d    = ptr_q;
		held_d   = held_q;
		phase_d  = phase_q;
		busy_d   = busy_q;
		pop      = 1'b0;
		result   = '0;
		unique case (item.func)
			FUNC_TICK: begin
				busy_d = can_xfer;
				if (can_xfer) begin
					pop = 1'b1;
					unique case (cfg.xfer_type)
						TYPE_REP2: begin
							if (!phase_q[0]) begin
								held_d = fifo_stat.rdata;
							end
							phase_d = {2'b00, phase_inc[0]};
						end
						TYPE_REP4: begin
							if (phase_q[1:0] == 2'b00) begin
								held_d = fifo_stat.rdata;
							end
							phase_d = {1'b0, phase_inc[1:0]};
						end
						TYPE_REP8: begin
							if (phase_q == 3'b111) begin
								held_d = fifo_stat.rdata;
							end
							phase_d = phase_inc;
						end
						default: begin
							held_d = fifo_stat.rdata;
						end
					endcase
					result.ram_write = 1'b1;
					result.ram_index = ptr_q[PTR_W-1:1];
					result.ram_data  = held_d;
					ptr_d            = ptr_q + PTR_W'(2);
				end
			end
			FUNC_ADDR: begin
				ptr_d = {item.data, 3'b000};
			end
			FUNC_PUSH: begin
				result.fifo_overflow = fifo_stat.full;
			end
			default: begin
			end
		endcase
		result.busy_res = busy_d;
	end

	assign fifo_ctl.push  = advance && (item.func == FUNC_PUSH);
	assign fifo_ctl.pop   = advance && pop;
	assign fifo_ctl.wdata = item.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			held_q  <= '0;
			phase_q <= '0;
			busy_q  <= 1'b0;
		end else if (advance) begin
			ptr_q   <= ptr_d;
			held_q  <= held_d;
			phase_q <= phase_d;
			busy_q  <= busy_d;
		end
	end

endmodule

// ----- design/sound_ram_fifo_transfer_unit.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sound_ram_fifo_transfer_unit: FIFO to sample RAM write engine
// Accepts ticks, address writes and halfword pushes, and returns one result
// beat per item describing the sample RAM write it caused.
// -----------------------------------------------------------------------------
// The unit takes one item per clock cycle, back to back, with no gaps, while
// the result side keeps taking beats: each item is at most one FIFO push or
// one FIFO pop plus one RAM write decision, done in a single combinational
// pass between the input register and the result register. The edge that
// accepts an item loads the input register; the result register is loaded
// when the item advances, and the result beat holds until taken. While a
// result waits, the input side takes one more beat into the input register
// and then stalls until the result is taken. The FIFO is 32 words of register
// storage, so there is no clearing pass after reset. Words popped from a FIFO
// slot that was never written are undefined. Configuration writes are taken
// at any cycle and must only be issued while the unit is idle.
// -----------------------------------------------------------------------------
module sound_ram_fifo_transfer_unit
	import srft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input item stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,    // [15:0] data
	input  logic [1:0]        s_tuser,    // [1:0] func
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,    // [17:0] ram_index, [33:18] ram_data,
	                                      // [34] busy_res, [35] fifo_overflow
	output logic [0:0]        m_tuser,    // [0] ram_write
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CDAT_W-1:0] cfg_data
);

	// input register
	logic       valid_s1;
	item_t      item_s1;
	// result register
	logic       valid_s2;
	result_t    result_s2;

	cfg_t       cfg_q;
	result_t    result_d;
	fifo_ctl_t  fifo_ctl;
	fifo_stat_t fifo_stat;
	logic       advance;
	logic       s_fire;

	// Advance the item in the input register when the result register is free
	// or is being emptied in this same cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input register: no reset
	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.func <= func_t'(s_tuser);
			item_s1.data <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// Configuration registers: always ready, drop writes beyond the list.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= '0;
			cfg_q.xfer_type <= TYPE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MODE) begin
				cfg_q.mode <= cfg_data[MODE_W-1:0];
			end else if (cfg_index == CFG_TYPE) begin
				cfg_q.xfer_type <= cfg_data[TYPE_W-1:0];
			end
		end
	end

	srft_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.stat   (fifo_stat)
	);

	srft_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.fifo_stat (fifo_stat),
		.fifo_ctl  (fifo_ctl),
		.result    (result_d)
	);

	// Pack the result beat: zeros fill the top nibble.
	assign m_tvalid   = valid_s2;
	assign m_tuser[0] = result_s2.ram_write;
	assign m_tdata    = {4'b0000, result_s2.fifo_overflow, result_s2.busy_res,
	                     result_s2.ram_data, result_s2.ram_index};

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------

	// fill count never passes the FIFO depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.count <= FIFO_CW'(FIFO_DEPTH))
		else $error("FIFO count beyond depth");

	// a pop is only requested with a word in the FIFO
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_ctl.pop |-> !fifo_stat.empty)
		else $error("pop from empty FIFO");

	// a RAM write leaves the engine busy
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.ram_write) |-> result_s2.busy_res)
		else $error("RAM write without busy");

	// an overflow result comes only from a push into a full FIFO
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result_d.fifo_overflow) |-> (fifo_stat.full && !fifo_ctl.pop))
		else $error("overflow flagged without full FIFO");

endmodule

// ----- tb/sound_ram_fifo_transfer_unit_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sound_ram_fifo_transfer_unit_tb: self-checking bench for the FIFO to RAM engine
// Drives ticks, address writes and halfword pushes through the input stream,
// predicts each result beat from a private copy of the FIFO, byte pointer,
// held word and repeat phase, and checks every beat field by field. Runs a
// directed opening, a full-FIFO burst, then random phases under each transfer
// mode and type, with random gaps and stalls on both sides.
// -----------------------------------------------------------------------------
module sound_ram_fifo_transfer_unit_tb;
	import srft_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 6;      // extra wait once every expected beat is back
	localparam int LONG_HOLD     = 60;     // receiver hold-off, well past the pipeline depth
	localparam int PHASE_ITEMS   = 30;
	localparam int NUM_SETTINGS  = 14;

	// -------------------------------------------------------------------------
	// Predictor and store of expected RAM write beats
	// -------------------------------------------------------------------------
	class ram_write_scoreboard;
		logic [WORD_W-1:0]  fifo_mem [FIFO_DEPTH];
		int unsigned        rd_pos;
		int unsigned        depth_used;
		logic [PTR_W-1:0]   byte_ptr;
		logic [WORD_W-1:0]  held;
		logic [PHASE_W-1:0] rep_phase;
		logic               busy;
		logic [MODE_W-1:0]  mode;
		logic [TYPE_W-1:0]  xtype;
		result_t            expected_beats [$];
		int                 mismatches;
		int                 items_seen;
		int                 writes_seen;
		int                 drops_seen;

		function new();
			rd_pos      = 0;
			depth_used  = 0;
			byte_ptr    = '0;
			held        = '0;
			rep_phase   = '0;
			busy        = 1'b0;
			mode        = '0;
			xtype       = TYPE_RESET;
			mismatches  = 0;
			items_seen  = 0;
			writes_seen = 0;
			drops_seen  = 0;
		endfunction

		function void set_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
			if (idx == CFG_MODE)
				mode = val[MODE_W-1:0];
			else if (idx == CFG_TYPE)
				xtype = val;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// Work out the beat that one accepted item causes and queue it.
		function void note_item(func_t f, logic [WORD_W-1:0] d);
			result_t           r;
			logic [WORD_W-1:0] w;
			r = '0;
			items_seen++;
			case (f)
				FUNC_TICK: begin
					if (mode != MODE_MANUAL || depth_used == 0) begin
						busy = 1'b0;
					end else begin
						busy       = 1'b1;
						w          = fifo_mem[rd_pos];
						rd_pos     = (rd_pos + 1) % FIFO_DEPTH;
						depth_used = depth_used - 1;
						case (xtype)
							TYPE_REP2: begin
								if (rep_phase[0] == 1'b0)
									held = w;
								rep_phase = {2'b00, ~rep_phase[0]};
							end
							TYPE_REP4: begin
								if (rep_phase[1:0] == 2'd0)
									held = w;
								rep_phase = {1'b0, rep_phase[1:0] + 2'd1};
							end
							TYPE_REP8: begin
								// rep8 latches at the last phase, so early writes reuse an old word
								if (rep_phase == 3'd7)
									held = w;
								rep_phase = rep_phase + 3'd1;
							end
							default: held = w;
						endcase
						r.ram_write = 1'b1;
						r.ram_index = byte_ptr[PTR_W-1:1];
						r.ram_data  = held;
						byte_ptr    = byte_ptr + 19'd2;
						writes_seen++;
					end
				end
				FUNC_ADDR: byte_ptr = {d, 3'b000};
				FUNC_PUSH: begin
					if (depth_used >= FIFO_DEPTH) begin
						r.fifo_overflow = 1'b1;
						drops_seen++;
					end else begin
						fifo_mem[(rd_pos + depth_used) % FIFO_DEPTH] = d;
						depth_used = depth_used + 1;
					end
				end
				default: ;
			endcase
			r.busy_res = busy;
			expected_beats.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// Check one result beat against the oldest expectation.
		function void check_beat(result_t got);
			result_t want;
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none, actual %h",
					$time, got);
				mismatches++;
				return;
			end
			want = expected_beats[0];
			expected_beats.delete(0);
			compare_field("ram_write",     32'(want.ram_write),     32'(got.ram_write));
			compare_field("ram_index",     32'(want.ram_index),     32'(got.ram_index));
			compare_field("ram_data",      32'(want.ram_data),      32'(got.ram_data));
			compare_field("busy_res",      32'(want.busy_res),      32'(got.busy_res));
			compare_field("fifo_overflow", 32'(want.fifo_overflow), 32'(got.fifo_overflow));
		endfunction
	endclass

	// -------------------------------------------------------------------------
	// Clock, reset and block ports
	// -------------------------------------------------------------------------
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata   = '0;
	logic [1:0]        s_tuser   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [39:0]       m_tdata;
	logic [0:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CDAT_W-1:0] cfg_data  = '0;

	ram_write_scoreboard sb;
	result_t             seen_beat;

	// Random gaps and stalls are switched per phase so that both busy and
	// back-to-back stretches occur; the long hold is requested by the sender
	// and counted out by the receiver.
	bit                  src_gaps_on   = 1'b1;
	bit                  sink_stall_on = 1'b1;
	bit                  sink_hold_req = 1'b0;
	int                  settings_run  = 0;

	always #CLK_HALF clk = ~clk;

	sound_ram_fifo_transfer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// -------------------------------------------------------------------------
	// Result side: draw a stall before each beat, honor a long hold request
	// -------------------------------------------------------------------------
	initial begin : result_sink
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = sink_stall_on ? $urandom_range(0, 8) : 0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Unpack each accepted beat and hand it to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_beat.ram_write     = m_tuser[0];
			seen_beat.ram_index     = m_tdata[17:0];
			seen_beat.ram_data      = m_tdata[33:18];
			seen_beat.busy_res      = m_tdata[34];
			seen_beat.fifo_overflow = m_tdata[35];
			sb.check_beat(seen_beat);
		end
	end

	// -------------------------------------------------------------------------
	// Sender tasks
	// -------------------------------------------------------------------------

	// Offer one item after a random gap and hold it until taken. Valid stays
	// high on return so the next item can follow back to back.
	task automatic send_item(func_t f, logic [WORD_W-1:0] d);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_item(f, d);
	endtask

	// Drop valid and wait until every expected beat has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	// Registers change only with the block idle.
	task automatic apply_setting(logic [MODE_W-1:0] m, logic [TYPE_W-1:0] t);
		drain_results();
		write_reg(CFG_MODE, m);
		write_reg(CFG_TYPE, t);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// Mostly random halfwords, with the all-zero and all-one extremes mixed in.
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	// Random addresses, biased toward the top so the 19-bit wrap is hit.
	function automatic logic [WORD_W-1:0] rand_addr();
		if ($urandom_range(0, 3) == 0)
			return 16'hFFFF - WORD_W'($urandom_range(0, 3));
		return WORD_W'($urandom);
	endfunction

	// One random phase: mostly push bursts drained by ticks, with address
	// writes, lone ticks and pushes, unused codes and the odd overfill.
	task automatic run_phase(int n_items);
		int target;
		int k;
		int roll;
		target = sb.items_seen + n_items;
		while (sb.items_seen < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				k = $urandom_range(1, 12);
				repeat (k) send_item(FUNC_PUSH, rand_word());
				repeat ($urandom_range((k > 2) ? k - 2 : 0, k + 2))
					send_item(FUNC_TICK, WORD_W'($urandom));
			end else if (roll < 70) begin
				send_item(FUNC_ADDR, rand_addr());
			end else if (roll < 85) begin
				send_item(FUNC_TICK, WORD_W'($urandom));
			end else if (roll < 93) begin
				send_item(FUNC_PUSH, rand_word());
			end else if (roll < 98) begin
				send_item(FUNC_NONE, WORD_W'($urandom));
			end else begin
				repeat (FIFO_DEPTH + 3) send_item(FUNC_PUSH, rand_word());
			end
		end
	endtask

	// -------------------------------------------------------------------------
	// Main sequence
	// -------------------------------------------------------------------------
	logic [MODE_W-1:0] setting_mode [NUM_SETTINGS] =
		'{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd1, 2'd1};
	logic [TYPE_W-1:0] setting_type [NUM_SETTINGS] =
		'{3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd6, 3'd7, 3'd5, 3'd3, 3'd7, 3'd5, 3'd3, 3'd4};

	initial begin : main_seq
		int fails;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: transfers stopped, normal type.
		send_item(FUNC_TICK, 16'hFFFF);     // idle tick on an empty FIFO
		send_item(FUNC_NONE, 16'hA5A5);     // unused code, no write
		send_item(FUNC_PUSH, 16'h0000);
		send_item(FUNC_PUSH, 16'hFFFF);
		send_item(FUNC_ADDR, 16'hFFFF);     // pointer at the top of RAM
		send_item(FUNC_TICK, 16'h0000);     // stopped mode holds the FIFO

		apply_setting(MODE_MANUAL, TYPE_NORMAL);
		send_item(FUNC_TICK, 16'h0000);
		send_item(FUNC_NONE, 16'h5A5A);     // busy survives an unused code
		send_item(FUNC_TICK, 16'h0000);
		send_item(FUNC_TICK, 16'h0000);     // FIFO now empty: busy clears
		send_item(FUNC_PUSH, 16'h8001);
		send_item(FUNC_PUSH, 16'h7FFE);
		send_item(FUNC_PUSH, 16'h5555);
		repeat (3) send_item(FUNC_TICK, 16'hFFFF);   // last one wraps to index 0
		send_item(FUNC_ADDR, 16'h0000);
		send_item(FUNC_PUSH, 16'hAAAA);
		send_item(FUNC_TICK, 16'h1234);

		// Overfill the FIFO, then empty it again.
		repeat (FIFO_DEPTH + 2) send_item(FUNC_PUSH, rand_word());
		repeat (FIFO_DEPTH + 2) send_item(FUNC_TICK, WORD_W'($urandom));

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			apply_setting(setting_mode[p], setting_type[p]);
			src_gaps_on   = (p % 3 != 2);
			sink_stall_on = (p % 4 != 3);
			if (p == 3) begin
				// Hold results off while the sender keeps offering, so the
				// block backs up and stalls its input.
				src_gaps_on   = 1'b0;
				sink_hold_req = 1'b1;
				repeat (20) send_item(FUNC_PUSH, rand_word());
				repeat (10) send_item(FUNC_TICK, WORD_W'($urandom));
			end
			run_phase(PHASE_ITEMS / 2);
			if (p == 6)
				drain_results();   // sender pause with nothing outstanding
			run_phase(PHASE_ITEMS / 2);
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		fails = sb.mismatches + sb.pending();
		$display("Covered %0d items over %0d register settings: %0d RAM writes, %0d dropped pushes.",
			sb.items_seen, settings_run + 1, sb.writes_seen, sb.drops_seen);
		$display("Included all transfer types, stopped modes, a long result hold and full FIFOs.");
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#2_000_000;
		$display("Timeout with %0d beats still expected", sb.pending());
		$display("== FAIL ==");
		$finish;
	end

endmodule
